>>> hw/rtl/slr_pkg.sv
// Shared types and constants for the synchronous-line receive framer.
// No dependencies; imported by every module of the block.
package slr_pkg;

    localparam int MSGN   = 8;
    localparam int MSGLEN = 128;

    localparam logic OP_EVENT   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic       rx_done;
        logic       carrier;
        logic [7:0] rx_byte;
        logic       overrun;
    } slr_in_t;

    typedef struct packed {
        logic        write_en;
        logic [2:0]  slot;
        logic [6:0]  write_pos;
        logic [7:0]  write_byte;
        logic        msg_done;
        logic [7:0]  msg_len;
        logic        msg_error;
        logic        resync;
        logic [3:0]  ring_count;
        logic [15:0] overrun_count;
        logic [15:0] full_count;
        logic [15:0] long_count;
    } slr_out_t;

endpackage

>>> hw/rtl/slr_in_stage.sv
// Input register of the framer: holds one accepted item until the core takes it.
// Depends on slr_pkg.
module slr_in_stage
    import slr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  slr_in_t s_data,
    output logic    item_valid,
    output slr_in_t item,
    input  logic    take
);

    logic    vld_reg;
    slr_in_t data_reg;

    assign s_ready    = !vld_reg || take;
    assign item_valid = vld_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            vld_reg <= 1'b1;
        end else if (take) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

>>> hw/rtl/slr_core.sv
// Framing state and single-pass result logic of the receive framer.
// Depends on slr_pkg.
module slr_core
    import slr_pkg::*;
#(
    parameter int SLOTS   = MSGN,
    parameter int MAX_LEN = MSGLEN
)
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     fire,
    input  slr_in_t  item,
    output slr_out_t result
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RUN  = 2'd1,
        PH_FULL = 2'd2,
        PH_ERR  = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [SLOT_W-1:0]   fill_slot_reg, fill_slot_next;
    logic [SLOT_W-1:0]   oldest_slot_reg, oldest_slot_next;
    logic [CNT_W-1:0]    filled_reg, filled_next;
    logic [7:0]          byte_count_reg, byte_count_next;
    logic                error_flag_reg, error_flag_next;
    logic [15:0]         overrun_total_reg, overrun_total_next;
    logic [15:0]         full_total_reg, full_total_next;
    logic [15:0]         long_total_reg, long_total_next;
    logic [SLOT_W+2:0]   slot_ext;
    logic [CNT_W+3:0]    cnt_ext;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    always_comb begin
        phase_t ph;
        logic   do_run;
        logic   err;
        logic   finish;

        phase_next         = phase_reg;
        fill_slot_next     = fill_slot_reg;
        oldest_slot_next   = oldest_slot_reg;
        filled_next        = filled_reg;
        byte_count_next    = byte_count_reg;
        error_flag_next    = error_flag_reg;
        overrun_total_next = overrun_total_reg;
        full_total_next    = full_total_reg;
        long_total_next    = long_total_reg;
        result             = '0;
        ph                 = phase_reg;
        do_run             = 1'b0;
        err                = 1'b0;
        finish             = 1'b0;

        if (item.opcode == OP_RELEASE) begin
            if (filled_reg != '0) begin
                oldest_slot_next = next_slot(oldest_slot_reg);
                filled_next      = filled_reg - 1'b1;
            end
        end else begin
            case (ph)
                PH_IDLE: begin
                    if (item.rx_done) begin
                        if (filled_reg >= CNT_W'(SLOTS)) begin
                            full_total_next = full_total_reg + 16'd1;
                            phase_next      = PH_FULL;
                            ph              = PH_FULL;
                        end else begin
                            error_flag_next = 1'b0;
                            byte_count_next = 8'd0;
                            phase_next      = PH_RUN;
                            do_run          = 1'b1;
                        end
                    end
                end
                PH_RUN: do_run = 1'b1;
                default: ;
            endcase

            if (do_run) begin
                if (item.rx_done) begin
                    if (item.overrun) begin
                        overrun_total_next = overrun_total_reg + 16'd1;
                        err                = 1'b1;
                    end else if (byte_count_next == 8'(MAX_LEN)) begin
                        byte_count_next = byte_count_next + 8'd1;
                        long_total_next = long_total_reg + 16'd1;
                        err             = 1'b1;
                    end else begin
                        result.write_en   = 1'b1;
                        result.write_pos  = byte_count_next[6:0];
                        result.write_byte = item.rx_byte;
                        byte_count_next   = byte_count_next + 8'd1;
                    end
                end
                if (err) begin
                    error_flag_next = 1'b1;
                    phase_next      = PH_ERR;
                end
                if (!item.carrier) begin
                    finish = 1'b1;
                end
            end else if (ph == PH_FULL) begin
                if (!item.carrier) begin
                    phase_next    = PH_IDLE;
                    result.resync = 1'b1;
                end
            end else if (ph == PH_ERR) begin
                if (!item.carrier) begin
                    finish = 1'b1;
                end
            end

            if (finish) begin
                result.msg_done  = 1'b1;
                result.msg_len   = byte_count_next;
                result.msg_error = error_flag_next;
                fill_slot_next   = next_slot(fill_slot_reg);
                filled_next      = filled_reg + 1'b1;
                phase_next       = PH_IDLE;
                result.resync    = 1'b1;
            end
        end

        slot_ext             = {3'b000, fill_slot_reg};
        cnt_ext              = {4'b0000, filled_next};
        result.slot          = slot_ext[2:0];
        result.ring_count    = cnt_ext[3:0];
        result.overrun_count = overrun_total_next;
        result.full_count    = full_total_next;
        result.long_count    = long_total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            fill_slot_reg     <= '0;
            oldest_slot_reg   <= '0;
            filled_reg        <= '0;
            byte_count_reg    <= 8'd0;
            error_flag_reg    <= 1'b0;
            overrun_total_reg <= 16'd0;
            full_total_reg    <= 16'd0;
            long_total_reg    <= 16'd0;
        end else if (fire) begin
            phase_reg         <= phase_next;
            fill_slot_reg     <= fill_slot_next;
            oldest_slot_reg   <= oldest_slot_next;
            filled_reg        <= filled_next;
            byte_count_reg    <= byte_count_next;
            error_flag_reg    <= error_flag_next;
            overrun_total_reg <= overrun_total_next;
            full_total_reg    <= full_total_next;
            long_total_reg    <= long_total_next;
        end
    end

    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_W'(SLOTS))
        else $error("ring occupancy above slot count");

    a_done_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.msg_done |-> result.resync)
        else $error("message end without resync");

    a_write_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.write_en && result.msg_done |-> !result.msg_error)
        else $error("stored byte in errored message");

    a_fill_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !result.msg_done |=> fill_slot_reg == $past(fill_slot_reg))
        else $error("fill slot moved without message end");

endmodule

>>> hw/rtl/slr_out_stage.sv
// Result register of the framer: holds one result until the receiver takes it.
// Depends on slr_pkg.
module slr_out_stage
    import slr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     res_valid,
    input  slr_out_t res,
    output logic     load_ok,
    output logic     m_valid,
    input  logic     m_ready,
    output slr_out_t m_data
);

    logic     vld_reg;
    slr_out_t data_reg;

    assign load_ok = !vld_reg || m_ready;
    assign m_valid = vld_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (res_valid && load_ok) begin
            vld_reg <= 1'b1;
        end else if (m_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && load_ok) begin
            data_reg <= res;
        end
    end

endmodule

>>> hw/rtl/sync_line_rx_message_framer.sv
// Top level of the synchronous-line receive framer.
// Depends on slr_pkg, slr_in_stage, slr_core and slr_out_stage.
//
// Input channel s_valid/s_ready/s_data carries one item per transfer: a receiver
// line event (character, carrier, overrun) or a release of the oldest ring slot.
// Result channel m_valid/m_ready/m_data returns exactly one result per item:
// the byte write into the current slot, message completion with length and
// error flag, the resync pulse, ring occupancy and three wrapping statistics.
// Each result is registered: its item is held in the input register, then the result
// is loaded into the result register once that register is free or being taken.
// Throughput: one item per cycle while m_ready holds; the framing update is a
// single pass of logic between the input register and the result register.
// Reset (aresetn low, synchronous): the framer returns to idle with an empty
// ring, slot pointers at zero and all statistics cleared; both registers empty.
// Receiver stall: the result register holds its value and the input register
// holds one more item; s_ready drops once both are full and no state advances.
module sync_line_rx_message_framer
    import slr_pkg::*;
#(
    parameter int SLOTS   = MSGN,
    parameter int MAX_LEN = MSGLEN
)
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  slr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output slr_out_t m_data
);

    logic     item_valid;
    slr_in_t  item;
    slr_out_t result;
    logic     load_ok;
    logic     fire;

    assign fire = item_valid && load_ok;

    slr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .take       (fire)
    );

    slr_core #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .result  (result)
    );

    slr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res       (result),
        .load_ok   (load_ok),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> sim/slr_framer_checker.sv
`timescale 1ns / 1ps
// Checker for the synchronous-line receive framer: watches both channels, predicts each result.
// Compares results field by field in order. Depends on slr_pkg.
module slr_framer_checker
    import slr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  slr_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  slr_out_t m_data,
    output int       fail_count,
    output int       expected_left
);

    typedef enum logic [1:0] {
        LINE_IDLE,
        LINE_RUN,
        LINE_FULL,
        LINE_DISCARD
    } line_phase_t;

    localparam int SLOTS_N = MSGN;

    line_phase_t line_phase;
    logic [2:0]  fill_slot;
    logic [3:0]  ring_used;
    logic [7:0]  msg_bytes;
    logic        msg_bad;
    logic [15:0] overrun_total;
    logic [15:0] full_total;
    logic [15:0] long_total;

    slr_out_t expected_results[$];

    task automatic frame_predict(input slr_in_t item, output slr_out_t res);
        line_phase_t ph;
        bit bad;
        bit finish;
        res = '0;
        res.slot = fill_slot;
        bad = 1'b0;
        finish = 1'b0;
        if (item.opcode == OP_RELEASE) begin
            if (ring_used != 0) ring_used--;
        end else begin
            ph = line_phase;
            if (ph == LINE_IDLE && item.rx_done) begin
                if (ring_used >= SLOTS_N) begin
                    full_total++;
                    line_phase = LINE_FULL;
                    ph = LINE_FULL;
                end else begin
                    msg_bad = 1'b0;
                    msg_bytes = '0;
                    line_phase = LINE_RUN;
                    ph = LINE_RUN;
                end
            end
            case (ph)
                LINE_RUN: begin
                    if (item.rx_done) begin
                        if (item.overrun) begin
                            overrun_total++;
                            bad = 1'b1;
                        end else if (msg_bytes == MSGLEN) begin
                            msg_bytes++;
                            long_total++;
                            bad = 1'b1;
                        end else begin
                            res.write_en = 1'b1;
                            res.write_pos = msg_bytes[6:0];
                            res.write_byte = item.rx_byte;
                            msg_bytes++;
                        end
                    end
                    if (bad) begin
                        msg_bad = 1'b1;
                        line_phase = LINE_DISCARD;
                    end
                    finish = !item.carrier;
                end
                LINE_FULL: begin
                    if (!item.carrier) begin
                        line_phase = LINE_IDLE;
                        res.resync = 1'b1;
                    end
                end
                LINE_DISCARD: begin
                    finish = !item.carrier;
                end
                default: ;
            endcase
            if (finish) begin
                res.msg_done = 1'b1;
                res.msg_len = msg_bytes;
                res.msg_error = msg_bad;
                fill_slot = (fill_slot == SLOTS_N - 1) ? '0 : fill_slot + 1'b1;
                ring_used++;
                line_phase = LINE_IDLE;
                res.resync = 1'b1;
            end
        end
        res.ring_count = ring_used;
        res.overrun_count = overrun_total;
        res.full_count = full_total;
        res.long_count = long_total;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        slr_out_t want;
        if (!aresetn) begin
            line_phase = LINE_IDLE;
            fill_slot = '0;
            ring_used = '0;
            msg_bytes = '0;
            msg_bad = 1'b0;
            overrun_total = '0;
            full_total = '0;
            long_total = '0;
            expected_results.delete();
            expected_left = 0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("write_en", want.write_en, m_data.write_en);
                    check_field("slot", want.slot, m_data.slot);
                    check_field("write_pos", want.write_pos, m_data.write_pos);
                    check_field("write_byte", want.write_byte, m_data.write_byte);
                    check_field("msg_done", want.msg_done, m_data.msg_done);
                    check_field("msg_len", want.msg_len, m_data.msg_len);
                    check_field("msg_error", want.msg_error, m_data.msg_error);
                    check_field("resync", want.resync, m_data.resync);
                    check_field("ring_count", want.ring_count, m_data.ring_count);
                    check_field("overrun_count", want.overrun_count,
                                m_data.overrun_count);
                    check_field("full_count", want.full_count, m_data.full_count);
                    check_field("long_count", want.long_count, m_data.long_count);
                end
            end
            if (s_valid && s_ready) begin
                frame_predict(s_data, want);
                expected_results.push_back(want);
            end
            expected_left = expected_results.size();
        end
    end

endmodule

>>> sim/sync_line_rx_message_framer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the synchronous-line receive framer: clock, reset, stimulus and verdict.
// Depends on slr_pkg, sync_line_rx_message_framer and slr_framer_checker.
module sync_line_rx_message_framer_tb;
    import slr_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    slr_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    slr_out_t m_data;

    int fail_count;
    int expected_left;
    int items_sent = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;
    bit quiet = 1'b0;

    sync_line_rx_message_framer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    slr_framer_checker checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic send_item(input slr_in_t item);
        if (!quiet && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_line(input bit rx_done, input bit carrier, input logic [7:0] rx_byte,
                             input bit overrun);
        slr_in_t item;
        item.opcode = OP_EVENT;
        item.rx_done = rx_done;
        item.carrier = carrier;
        item.rx_byte = rx_byte;
        item.overrun = overrun;
        send_item(item);
    endtask

    task automatic send_release();
        slr_in_t item;
        item = slr_in_t'($urandom);
        item.opcode = OP_RELEASE;
        send_item(item);
    endtask

    // One message of len characters; end it on the last character or on a separate drop.
    task automatic send_message(input int len, input int overrun_pct, input bit end_on_char);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 6) send_release();
            if ($urandom_range(99) < 6) begin
                send_line(1'b0, 1'b1, 8'($urandom), 1'($urandom_range(1)));
            end
            send_line(1'b1, !(end_on_char && i == len - 1), 8'($urandom),
                      $urandom_range(99) < overrun_pct);
        end
        if (!end_on_char) send_line(1'b0, 1'b0, 8'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 8);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int pick;
        int len;
        bit hold_done;
        bit drain_done;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle line, release on an empty ring
        send_line(1'b0, 1'b1, 8'hFF, 1'b1);
        send_line(1'b0, 1'b0, 8'h00, 1'b0);
        send_release();
        // first character also ends the message
        send_line(1'b1, 1'b0, 8'hFF, 1'b0);
        send_line(1'b1, 1'b1, 8'h00, 1'b0);
        send_line(1'b1, 1'b1, 8'hA5, 1'b0);
        send_line(1'b0, 1'b0, 8'h5A, 1'b0);
        // overrun on the first character, rest discarded
        send_line(1'b1, 1'b1, 8'h3C, 1'b1);
        send_line(1'b1, 1'b1, 8'hC3, 1'b0);
        send_line(1'b0, 1'b0, 8'h00, 1'b0);
        // release in the middle of a message
        send_line(1'b1, 1'b1, 8'h81, 1'b0);
        send_item('{opcode: OP_RELEASE, rx_done: 1'b1, carrier: 1'b0, rx_byte: 8'hFF,
                    overrun: 1'b1});
        send_line(1'b1, 1'b1, 8'h7E, 1'b0);
        send_line(1'b0, 1'b0, 8'h00, 1'b0);
        // fill the ring, then start on a full ring
        repeat (5) send_line(1'b1, 1'b0, 8'($urandom), 1'b0);
        send_line(1'b1, 1'b1, 8'h11, 1'b0);
        send_line(1'b0, 1'b0, 8'h22, 1'b0);
        send_line(1'b1, 1'b0, 8'h33, 1'b1);

        // exact maximum length, then one past it
        repeat (MSGN) send_release();
        send_message(MSGLEN, 0, 1'b0);
        send_message(MSGLEN + 1, 0, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 450 && !hold_done) begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            quiet = (items_sent >= 550 && items_sent < 680);
            if (items_sent >= 720 && !drain_done) begin
                drain_results();
                drain_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 60) begin
                len = ($urandom_range(59) == 0) ? $urandom_range(125, 134)
                                                : $urandom_range(1, 12);
                send_message(len, 4, 1'($urandom_range(1)));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3)) send_release();
            end else begin
                send_item(slr_in_t'($urandom));
            end
        end
        quiet = 1'b0;

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && expected_left == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/slr_pkg.sv
hw/rtl/slr_in_stage.sv
hw/rtl/slr_core.sv
hw/rtl/slr_out_stage.sv
hw/rtl/sync_line_rx_message_framer.sv
sim/slr_framer_checker.sv
sim/sync_line_rx_message_framer_tb.sv
